// ===== hdl/strided_2d_cross_correlation_top_macros.svh =====
// Assertion macros for the strided 2-D cross-correlation block.
// Used by the port checker; needs clk and rst in scope.
`ifndef STRIDED_2D_CROSS_CORRELATION_TOP_MACROS_SVH
`define STRIDED_2D_CROSS_CORRELATION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define S2DCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s2dcc check failed");

// Next-cycle implication, checked outside reset.
`define S2DCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s2dcc check failed");

`endif

// ===== hdl/s2dcc_pkg.sv =====
// Shared constants, codes and command/status types for the cross-correlation block.
// No dependencies.
package s2dcc_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int MAX_MAP     = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 40;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE);
  localparam int MAP_BITS    = $clog2(MAX_MAP);
  localparam int DIM_BITS    = 7;
  localparam int MDIM_BITS   = 4;
  localparam int IMG_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int KER_DEPTH   = MAX_MAP * MAX_MAP;
  localparam int DIV_STEPS   = SIDE_BITS;
  localparam int PIPE_DEPTH  = 2;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;

  localparam logic [1:0] MODE_SAME  = 2'd0;
  localparam logic [1:0] MODE_VALID = 2'd1;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_STRIDE   = 3'd1;
  localparam logic [2:0] REG_IN_ROWS  = 3'd2;
  localparam logic [2:0] REG_IN_COLS  = 3'd3;
  localparam logic [2:0] REG_MAP_ROWS = 3'd4;
  localparam logic [2:0] REG_MAP_COLS = 3'd5;

  typedef struct packed {
    logic                accept;
    logic                req_load;
    logic                div_step;
    logic                setup;
    logic                base;
    logic                issue;
    logic [MAP_BITS-1:0] tap_r;
    logic [MAP_BITS-1:0] tap_c;
    logic                res_load;
  } cmd_t;

  typedef struct packed {
    logic                 in_range;
    logic                 zero_out;
    logic [MDIM_BITS-1:0] map_rows;
    logic [MDIM_BITS-1:0] map_cols;
    logic                 out_busy;
  } stat_t;

endpackage

// ===== hdl/s2dcc_dp.sv =====
// Datapath: configuration registers, stores, divider, address set-up, MAC and result register.
// Depends on s2dcc_pkg.
module s2dcc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  s2dcc_pkg::cmd_t      cmd,
  output s2dcc_pkg::stat_t     stat,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic [1:0]           kind,
  input  logic [5:0]           row,
  input  logic [5:0]           col,
  input  logic signed [15:0]   value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [39:0]   sum,
  output logic                 out_of_range
);
  import s2dcc_pkg::*;

  logic [1:0]           mode;
  logic [3:0]           stride;
  logic [DIM_BITS-1:0]  in_rows, in_cols;
  logic [MDIM_BITS-1:0] map_rows, map_cols;

  logic [3:0]           s_eff;
  logic [DIM_BITS-1:0]  ir, ic;
  logic [MDIM_BITS-1:0] mr, mc;

  logic signed [SAMPLE_BITS-1:0] ker_mem [KER_DEPTH];
  logic signed [SAMPLE_BITS-1:0] img_mem [IMG_DEPTH];

  logic [SIDE_BITS-1:0] req_row, req_col;
  logic [SIDE_BITS-1:0] n_r, n_c, q_r, q_c;
  logic [3:0]           rm_r, rm_c;
  logic [4:0]           t_r, t_c;
  logic                 ge_r, ge_c;

  logic signed [11:0]   total_r, total_c, pad_r, pad_c, base_y, base_x;
  logic [9:0]           rs_r, rs_c, row_s, col_s;
  logic                 in_range;

  logic signed [11:0]   y, x;
  logic                 in_window;
  logic signed [SAMPLE_BITS-1:0] img_q, ker_q;
  logic                 v1, v2;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0] acc;

  function automatic logic signed [11:0] half_trunc(input logic signed [11:0] t);
    logic signed [11:0] mag;
    mag = t[11] ? -t : t;
    mag = mag >>> 1;
    return t[11] ? -mag : mag;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_VALID;
      stride   <= 4'd1;
      in_rows  <= DIM_BITS'(MAX_SIDE);
      in_cols  <= DIM_BITS'(MAX_SIDE);
      map_rows <= MDIM_BITS'(3);
      map_cols <= MDIM_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode     <= cfg_data[1:0];
        REG_STRIDE:   stride   <= cfg_data[3:0];
        REG_IN_ROWS:  in_rows  <= cfg_data;
        REG_IN_COLS:  in_cols  <= cfg_data;
        REG_MAP_ROWS: map_rows <= cfg_data[3:0];
        REG_MAP_COLS: map_cols <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s_eff = (stride == 4'd0) ? 4'd1 : stride;
  assign ir = (in_rows == '0) ? DIM_BITS'(1) :
              (in_rows > DIM_BITS'(MAX_SIDE)) ? DIM_BITS'(MAX_SIDE) : in_rows;
  assign ic = (in_cols == '0) ? DIM_BITS'(1) :
              (in_cols > DIM_BITS'(MAX_SIDE)) ? DIM_BITS'(MAX_SIDE) : in_cols;
  assign mr = (map_rows == '0) ? MDIM_BITS'(1) :
              (map_rows > MDIM_BITS'(MAX_MAP)) ? MDIM_BITS'(MAX_MAP) : map_rows;
  assign mc = (map_cols == '0) ? MDIM_BITS'(1) :
              (map_cols > MDIM_BITS'(MAX_MAP)) ? MDIM_BITS'(MAX_MAP) : map_cols;

  // stores
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_WEIGHT && row < SIDE_BITS'(MAX_MAP)
        && col < SIDE_BITS'(MAX_MAP))
      ker_mem[{row[MAP_BITS-1:0], col[MAP_BITS-1:0]}] <= value;
    ker_q <= ker_mem[{cmd.tap_r, cmd.tap_c}];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_SAMPLE)
      img_mem[{row, col}] <= value;
    img_q <= img_mem[{y[SIDE_BITS-1:0], x[SIDE_BITS-1:0]}];
  end

  // divider: floor((in-1)/stride), one quotient bit per step
  assign t_r  = {rm_r, n_r[SIDE_BITS-1]};
  assign t_c  = {rm_c, n_c[SIDE_BITS-1]};
  assign ge_r = t_r >= {1'b0, s_eff};
  assign ge_c = t_c >= {1'b0, s_eff};

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_row <= row;
      req_col <= col;
      n_r     <= SIDE_BITS'(ir - DIM_BITS'(1));
      n_c     <= SIDE_BITS'(ic - DIM_BITS'(1));
      rm_r    <= '0;
      rm_c    <= '0;
      q_r     <= '0;
      q_c     <= '0;
    end else if (cmd.div_step) begin
      rm_r <= ge_r ? 4'(t_r - {1'b0, s_eff}) : t_r[3:0];
      rm_c <= ge_c ? 4'(t_c - {1'b0, s_eff}) : t_c[3:0];
      q_r  <= {q_r[SIDE_BITS-2:0], ge_r};
      q_c  <= {q_c[SIDE_BITS-2:0], ge_c};
      n_r  <= n_r << 1;
      n_c  <= n_c << 1;
    end
  end

  // padding, range check and window origin
  assign total_r = $signed({2'b0, {4'b0, q_r} * {6'b0, s_eff}}) + $signed({8'b0, mr})
                   - $signed({5'b0, ir});
  assign total_c = $signed({2'b0, {4'b0, q_c} * {6'b0, s_eff}}) + $signed({8'b0, mc})
                   - $signed({5'b0, ic});
  assign row_s = {4'b0, req_row} * {6'b0, s_eff};
  assign col_s = {4'b0, req_col} * {6'b0, s_eff};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rs_r  <= row_s;
      rs_c  <= col_s;
      pad_r <= (mode == MODE_SAME) ? half_trunc(total_r) : 12'sd0;
      pad_c <= (mode == MODE_SAME) ? half_trunc(total_c) : 12'sd0;
      if (mode == MODE_VALID)
        in_range <= ({1'b0, row_s} + 11'(mr) <= 11'(ir)) &&
                    ({1'b0, col_s} + 11'(mc) <= 11'(ic));
      else
        in_range <= (row_s < 10'(ir)) && (col_s < 10'(ic));
    end
    if (cmd.base) begin
      base_y <= $signed({2'b0, rs_r}) - pad_r;
      base_x <= $signed({2'b0, rs_c}) - pad_c;
    end
  end

  assign y = base_y + $signed({9'b0, cmd.tap_r});
  assign x = base_x + $signed({9'b0, cmd.tap_c});
  assign in_window = !y[11] && !x[11] && (y < $signed({5'b0, ir}))
                     && (x < $signed({5'b0, ic}));

  // multiply-accumulate pipeline: read, multiply, add
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue && in_window;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= img_q * ker_q;
    if (cmd.req_load)
      acc <= '0;
    else if (v2)
      acc <= acc + SUM_BITS'(prod);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      sum          <= (in_range && !mode[1]) ? acc : '0;
      out_of_range <= !in_range;
    end
  end

  assign stat.in_range = in_range;
  assign stat.zero_out = mode[1];
  assign stat.map_rows = mr;
  assign stat.map_cols = mc;
  assign stat.out_busy = out_valid;

endmodule

// ===== hdl/s2dcc_ctrl.sv =====
// Controller: sequences division, set-up, the kernel tap walk and result hand-off.
// Depends on s2dcc_pkg.
module s2dcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  s2dcc_pkg::stat_t stat,
  output s2dcc_pkg::cmd_t  cmd
);
  import s2dcc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_BASE  = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state, state_next;
  logic [2:0]          cnt, cnt_next;
  logic [MAP_BITS-1:0] tap_r, tap_c, tap_r_next, tap_c_next;
  logic                accept, last_c, last_r;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_c   = ({1'b0, tap_c} == stat.map_cols - MDIM_BITS'(1));
  assign last_r   = ({1'b0, tap_r} == stat.map_rows - MDIM_BITS'(1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    tap_r_next = tap_r;
    tap_c_next = tap_c;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept && kind == KIND_PIXEL) state_next = ST_DIV;
      end
      ST_DIV: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'(DIV_STEPS - 1)) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_BASE;
      ST_BASE: begin
        tap_r_next = '0;
        tap_c_next = '0;
        state_next = (stat.in_range && !stat.zero_out) ? ST_MAC : ST_DONE;
      end
      ST_MAC: begin
        cnt_next = '0;
        if (last_c) begin
          tap_c_next = '0;
          tap_r_next = tap_r + MAP_BITS'(1);
          if (last_r) state_next = ST_DRAIN;
        end else begin
          tap_c_next = tap_c + MAP_BITS'(1);
        end
      end
      ST_DRAIN: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'(PIPE_DEPTH - 1)) state_next = ST_DONE;
      end
      ST_DONE: if (!stat.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      tap_r <= '0;
      tap_c <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      tap_r <= tap_r_next;
      tap_c <= tap_c_next;
    end
  end

  assign cmd.accept   = accept;
  assign cmd.req_load = accept && kind == KIND_PIXEL;
  assign cmd.div_step = (state == ST_DIV);
  assign cmd.setup    = (state == ST_SETUP);
  assign cmd.base     = (state == ST_BASE);
  assign cmd.issue    = (state == ST_MAC);
  assign cmd.tap_r    = tap_r;
  assign cmd.tap_c    = tap_c;
  assign cmd.res_load = (state == ST_DONE) && !stat.out_busy;

endmodule

// ===== hdl/strided_2d_cross_correlation_top.sv =====
// Top level of the strided 2-D cross-correlation block.
// Depends on s2dcc_pkg, s2dcc_ctrl and s2dcc_dp.
// Input channel (in_valid/in_ready): one beat per item; kind 0 writes a kernel
//   weight, kind 1 writes an image sample, kind 2 requests the output pixel at
//   (row, col). Writes are taken back to back and return nothing.
// Output channel (out_valid/out_ready): one beat per request, the exact 40-bit
//   sum, or out_of_range set with a zero sum.
// Config port: cfg_we with cfg_index/cfg_data writes a register;
//   write only while no request is in flight.
// Sequence: the divider steps, the set-up and base states, the walk over all
//   map_rows*map_cols kernel taps, the pipeline drain and the result load.
//   Out-of-range and all-zero requests skip the tap walk and the drain.
// Requests: no new beat is taken while a request is in flight; the next beat
//   is taken in the cycle after the result loads. The single MAC and the one
//   read port of each store set the length of the tap walk.
// Reset: configuration returns to valid mode, stride 1, 64x64 image, 3x3 kernel;
//   the stores keep their contents and must be written before use.
// Stall: a finished result waits in the output register; the block still takes
//   writes and starts the next request, and holds that one until the register frees.
module strided_2d_cross_correlation_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [5:0]          row,
  input  logic [5:0]          col,
  input  logic signed [15:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [39:0]  sum,
  output logic                out_of_range
);
  import s2dcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequence each request
  s2dcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold stores, do the arithmetic, drive the result beat
  s2dcc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .row          (row),
    .col          (col),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sum          (sum),
    .out_of_range (out_of_range)
  );

endmodule

// ===== hdl/s2dcc_check.sv =====
// Port-level checker for the cross-correlation block, bound to the top level.
// Depends on s2dcc_pkg and strided_2d_cross_correlation_top_macros.svh.
`include "strided_2d_cross_correlation_top_macros.svh"

module s2dcc_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [39:0] sum,
  input logic               out_of_range
);
  import s2dcc_pkg::*;

  `S2DCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(sum) && $stable(out_of_range))
  `S2DCC_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, sum == 40'sd0)
  `S2DCC_ASSERT_NEXT(a_req_busy, in_valid && in_ready && kind == KIND_PIXEL, !in_ready)
  `S2DCC_ASSERT_NOW(a_result_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind strided_2d_cross_correlation_top s2dcc_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .kind         (kind),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sum          (sum),
  .out_of_range (out_of_range)
);

// ===== tb/strided_2d_cross_correlation_top_test.sv =====
// Self-checking testbench for the strided 2-D cross-correlation block.
// Depends on s2dcc_pkg and strided_2d_cross_correlation_top; nothing else.
`timescale 1ns / 1ps

module strided_2d_cross_correlation_top_test;
  import s2dcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_ITEMS   = 1000;

  // Codes with no name in the package: spare kind, all-zero and spare modes.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] MODE_ZERO  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Idling phases: probabilities out of a hundred for sender gap and receiver stall.
  localparam int PH_NONE = 0, PH_SEND = 1, PH_RECV = 2, PH_BOTH = 3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [6:0]          cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          kind = KIND_WEIGHT;
  logic [5:0]          row = '0;
  logic [5:0]          col = '0;
  logic signed [15:0]  value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [39:0]  sum;
  logic                out_of_range;

  strided_2d_cross_correlation_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .row(row), .col(col), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .sum(sum), .out_of_range(out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic signed [39:0] sum;
    logic               oor;
  } pixel_t;

  typedef struct {
    logic [1:0]         kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
    logic               known;   // expected result typed in below
    pixel_t             pix;
  } stim_t;

  // Shadow of the block: configuration and both stores.
  logic [1:0]         sh_mode;
  logic [3:0]         sh_stride;
  logic [6:0]         sh_in_rows, sh_in_cols;
  logic [3:0]         sh_map_rows, sh_map_cols;
  logic signed [15:0] sh_kernel [KER_DEPTH];
  logic signed [15:0] sh_image  [IMG_DEPTH];
  bit                 ker_set   [KER_DEPTH];
  bit                 img_set   [IMG_DEPTH];

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     beats_out = 0;
  int     beats_in = 0;
  int     requests = 0;
  int     oor_seen = 0;
  int     idle_cycles = 0;
  int     phase = PH_NONE;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int out_side(int m, int in_n, int map_n, int s, output int pad);
    int o;
    pad = 0;
    if (m == MODE_VALID) begin
      if (map_n > in_n) return 0;
      return (in_n - map_n + s) / s;
    end
    o = (in_n + s - 1) / s;
    if (m == MODE_SAME) pad = ((o - 1) * s + map_n - in_n) / 2;
    return o;
  endfunction

  // Work out the pixel at (r, c) under the current shadow configuration.
  function automatic pixel_t correlate_pixel(int r, int c);
    pixel_t p;
    int m, s, ir, ic, mr, mc, orows, ocols, pr, pc, y, x;
    longint acc;
    m  = (sh_mode == MODE_SPARE) ? MODE_ZERO : sh_mode;
    s  = (sh_stride == 0) ? 1 : sh_stride;
    ir = clamp_dim(sh_in_rows, MAX_SIDE);
    ic = clamp_dim(sh_in_cols, MAX_SIDE);
    mr = clamp_dim(sh_map_rows, MAX_MAP);
    mc = clamp_dim(sh_map_cols, MAX_MAP);
    orows = out_side(m, ir, mr, s, pr);
    ocols = out_side(m, ic, mc, s, pc);
    acc = 0;
    p.oor = 1'b0;
    if (r >= orows || c >= ocols) begin
      p.oor = 1'b1;
    end else if (m != MODE_ZERO) begin
      for (int i = 0; i < mr; i++) begin
        y = r * s + i - pr;
        if (y < 0 || y >= ir) continue;
        for (int j = 0; j < mc; j++) begin
          x = c * s + j - pc;
          if (x < 0 || x >= ic) continue;
          acc += longint'(sh_kernel[i * MAX_MAP + j]) * longint'(sh_image[y * MAX_SIDE + x]);
        end
      end
    end
    p.sum = acc[39:0];
    return p;
  endfunction

  // True if the request reads only written entries (or reads nothing).
  function automatic bit reads_written(int r, int c);
    int m, s, ir, ic, mr, mc, orows, ocols, pr, pc, y, x;
    m  = (sh_mode == MODE_SPARE) ? MODE_ZERO : sh_mode;
    s  = (sh_stride == 0) ? 1 : sh_stride;
    ir = clamp_dim(sh_in_rows, MAX_SIDE);
    ic = clamp_dim(sh_in_cols, MAX_SIDE);
    mr = clamp_dim(sh_map_rows, MAX_MAP);
    mc = clamp_dim(sh_map_cols, MAX_MAP);
    orows = out_side(m, ir, mr, s, pr);
    ocols = out_side(m, ic, mc, s, pc);
    if (r >= orows || c >= ocols || m == MODE_ZERO) return 1;
    for (int i = 0; i < mr; i++) begin
      y = r * s + i - pr;
      if (y < 0 || y >= ir) continue;
      for (int j = 0; j < mc; j++) begin
        x = c * s + j - pc;
        if (x < 0 || x >= ic) continue;
        if (!ker_set[i * MAX_MAP + j] || !img_set[y * MAX_SIDE + x]) return 0;
      end
    end
    return 1;
  endfunction

  // Update the shadow for an accepted beat and queue the expected pixel.
  task automatic accept_item(input stim_t it);
    pixel_t p;
    case (it.kind)
      KIND_WEIGHT: begin
        if (it.row < MAX_MAP && it.col < MAX_MAP) begin
          sh_kernel[it.row * MAX_MAP + it.col] = it.value;
          ker_set[it.row * MAX_MAP + it.col] = 1'b1;
        end
      end
      KIND_SAMPLE: begin
        sh_image[it.row * MAX_SIDE + it.col] = it.value;
        img_set[it.row * MAX_SIDE + it.col] = 1'b1;
      end
      KIND_PIXEL: begin
        p = correlate_pixel(it.row, it.col);
        if (it.known && (p.sum !== it.pix.sum || p.oor !== it.pix.oor))
          report_mismatch("typed-in expectation", p.sum, it.pix.sum);
        pending_pixels.push_back(p);
        requests++;
      end
      default: ;
    endcase
  endtask

  function automatic int sender_gap();
    return (phase == PH_SEND) ? 58 : (phase == PH_BOTH) ? 35 : 0;
  endfunction

  // Offer one beat; hold valid and payload until it is taken. Valid stays high
  // after the beat so that a following beat can go straight out; settle drops it.
  task automatic send_item(input stim_t it);
    while ($urandom_range(99) < sender_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind; row <= it.row; col <= it.col; value <= it.value;
    do @(posedge clk); while (!in_ready);
    accept_item(it);
    beats_in++;
  endtask

  // Drive one register write; the caller drops the write enable after the last one.
  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data[6:0];
    @(posedge clk);
    case (idx)
      REG_MODE:     sh_mode = data[1:0];
      REG_STRIDE:   sh_stride = data[3:0];
      REG_IN_ROWS:  sh_in_rows = data[6:0];
      REG_IN_COLS:  sh_in_cols = data[6:0];
      REG_MAP_ROWS: sh_map_rows = data[3:0];
      REG_MAP_COLS: sh_map_cols = data[3:0];
      default: ;
    endcase
  endtask

  // Drop the input, wait for every queued pixel, then let any in-flight work settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int m, input int s, input int ir, input int ic,
                           input int mr, input int mc);
    settle();
    write_reg(REG_MODE, m);
    write_reg(REG_STRIDE, s);
    write_reg(REG_IN_ROWS, ir);
    write_reg(REG_IN_COLS, ic);
    write_reg(REG_MAP_ROWS, mr);
    write_reg(REG_MAP_COLS, mc);
    cfg_we <= 1'b0;
  endtask

  function automatic stim_t mk(logic [1:0] k, int r, int c, int v);
    stim_t it;
    it.kind = k; it.row = r[5:0]; it.col = c[5:0]; it.value = v[15:0];
    it.known = 1'b0; it.pix.sum = '0; it.pix.oor = 1'b0;
    return it;
  endfunction

  function automatic stim_t mk_known(int r, int c, longint s, bit oor);
    stim_t it;
    it = mk(KIND_PIXEL, r, c, 0);
    it.known = 1'b1; it.pix.sum = s[39:0]; it.pix.oor = oor;
    return it;
  endfunction

  // Fill the kernel and the image window in use with random values.
  task automatic fill_all(input int ir, input int ic, input int mr, input int mc);
    for (int i = 0; i < mr; i++)
      for (int j = 0; j < mc; j++)
        send_item(mk(KIND_WEIGHT, i, j, $urandom()));
    for (int i = 0; i < ir; i++)
      for (int j = 0; j < ic; j++)
        send_item(mk(KIND_SAMPLE, i, j, $urandom()));
  endtask

  // Receiver: stall per phase, or hold off entirely while hold_off is set.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= ((phase == PH_RECV) ? 58 :
                    (phase == PH_BOTH) ? 35 : 0));
    end
  end

  // Checker: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result beat", sum, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_of_range !== want.oor) report_mismatch("out_of_range", out_of_range, want.oor);
        if (sum !== want.sum) report_mismatch("sum", sum, want.sum);
        if (want.oor) oor_seen++;
      end
    end
  end

  // Watchdog: count cycles without any accepted beat, register write or hold-off.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_off || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_pixels.size());
      $display("strided_2d_cross_correlation_top verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering.
  initial begin
    wait (stim_done == 1'b0 && beats_in > 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    stim_t directed[$];
    int    sent;
    int    r, c, ir, ic, mr, mc, fr, fc;
    stim_t it;

    sh_mode = MODE_VALID; sh_stride = 1; sh_in_rows = 64; sh_in_cols = 64;
    sh_map_rows = 3; sh_map_cols = 3;
    foreach (ker_set[i]) ker_set[i] = 1'b0;
    foreach (img_set[i]) img_set[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reset defaults (valid 64x64, 3x3) then extremes.
    directed.push_back(mk_known(62, 0, 0, 1));           // just past valid output
    directed.push_back(mk_known(0, 63, 0, 1));
    directed.push_back(mk(KIND_WEIGHT, 63, 63, 16'h7fff)); // outside kernel store: dropped
    directed.push_back(mk(KIND_SPARE, 5, 5, 16'h1234));     // unused kind: dropped
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        directed.push_back(mk(KIND_WEIGHT, i, j, (i + j) % 2 ? -32768 : 32767));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        directed.push_back(mk(KIND_SAMPLE, i, j, (i + j) % 2 ? -32768 : 32767));
    // Largest magnitude: four products of (-32768)^2 and five of 32767^2.
    directed.push_back(mk_known(0, 0, 4 * 64'sd1073741824 + 5 * 64'sd1073676289, 0));
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // Extremes of the configuration: tiny image, large kernel, every mode.
    configure(MODE_VALID, 1, 2, 2, 8, 8);                // kernel larger than image
    send_item(mk_known(0, 0, 0, 1));
    configure(MODE_ZERO, 8, 64, 64, 1, 1);               // all-zero mode
    send_item(mk_known(7, 7, 0, 0));
    send_item(mk_known(8, 0, 0, 1));
    configure(MODE_SPARE, 0, 0, 0, 0, 0);                // unused codes and zero sizes
    send_item(mk_known(0, 0, 0, 0));
    configure(MODE_SAME, 15, 127, 127, 15, 15);          // beyond ranges: clamped, wide stride
    fill_all(6, 6, 8, 8);                                // window of pixel (0, 0)
    send_item(mk(KIND_PIXEL, 0, 0, 0));
    send_item(mk_known(5, 0, 0, 1));
    settle();

    // Random part: phases of configuration, each with a filled window and requests.
    sent = 0;
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      phase = ph % 4;
      mr = $urandom_range(1, 8); mc = $urandom_range(1, 8);
      ir = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      ic = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      if (ph % 11 == 5) begin ir = 64; ic = 64; mr = 8; mc = 8; end
      configure($urandom_range(3), $urandom_range(0, 9), ir, ic, mr, mc);
      // Large images get only their top-left corner; requests reading elsewhere are skipped.
      fr = (ir * ic <= 256) ? ir : clamp_dim(ir, 16);
      fc = (ir * ic <= 256) ? ic : clamp_dim(ic, 16);
      fill_all(fr, fc, mr, mc);
      sent += mr * mc + fr * fc;
      for (int n = 0; n < 40; n++) begin
        r = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(10);
        c = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(10);
        case ($urandom_range(9))
          0: it = mk(KIND_WEIGHT, $urandom_range(63), $urandom_range(63), $urandom());
          1: it = mk(KIND_SAMPLE, $urandom_range(63), $urandom_range(63), $urandom());
          2: it = mk(KIND_SPARE, $urandom_range(63), $urandom_range(63), $urandom());
          default: it = mk(KIND_PIXEL, r, c, $urandom());
        endcase
        if (it.kind == KIND_PIXEL && !reads_written(r, c)) continue;
        send_item(it);
        sent++;
      end
    end

    stim_done = 1'b1;
    phase = PH_NONE;
    settle();

    $display("covered %0d input beats, %0d pixel requests (%0d out of range)",
             beats_in, requests, oor_seen);
    $display("across all modes, strides and sizes with idle and stall phases");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("strided_2d_cross_correlation_top verification clean");
    end else begin
      $display("strided_2d_cross_correlation_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/s2dcc_pkg.sv
hdl/s2dcc_dp.sv
hdl/s2dcc_ctrl.sv
hdl/strided_2d_cross_correlation_top.sv
hdl/s2dcc_check.sv
tb/strided_2d_cross_correlation_top_test.sv
